// ===== sv/rgm_pkg.sv =====
// shared constants and types for the ramped gain unit
package rgm_pkg;

  localparam int GAIN_W    = 24;
  localparam int RAMP_W    = 21;
  localparam int CHAN_W    = 3;
  localparam int FRAC_BITS = 20;
  localparam int STEP_W    = GAIN_W + 1;

  localparam logic [GAIN_W-1:0] UNITY_GAIN  = GAIN_W'(1048576);
  localparam logic [RAMP_W-1:0] RAMP_RESET  = RAMP_W'(480);
  localparam logic [CHAN_W-1:0] CHAN_RESET  = CHAN_W'(2);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN   = 2'd2;

  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = GAIN_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  typedef struct packed {
    logic mul_en;
    logic sat_en;
  } lane_ctrl_t;

endpackage

// ===== sv/rgm_in_if.sv =====
// input frame channel: lane samples and frame flags
interface rgm_in_if #(
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 24
);
  logic                           valid;
  logic                           ready;
  logic [LANES*SAMPLE_BITS-1:0]   sample_lane;
  logic                           buffer_start;
  logic                           snap_to_target;

  modport source (output valid, sample_lane, buffer_start, snap_to_target, input ready);
  modport sink   (input valid, sample_lane, buffer_start, snap_to_target, output ready);
endinterface

// ===== sv/rgm_out_if.sv =====
// output frame channel: scaled lane samples and applied gain
interface rgm_out_if #(
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 24
);
  logic                           valid;
  logic                           ready;
  logic [LANES*SAMPLE_BITS-1:0]   out_lane;
  logic [23:0]                    gain_applied;

  modport source (output valid, out_lane, gain_applied, input ready);
  modport sink   (input valid, out_lane, gain_applied, output ready);
endinterface

// ===== sv/rgm_div.sv =====
// radix-16 restoring divider for the ramp increment
module rgm_div import rgm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [GAIN_W-1:0] dividend,
  input  logic [RAMP_W-1:0] divisor,
  output logic              done,
  output logic [GAIN_W-1:0] quotient
);

  logic [GAIN_W-1:0]    quo;
  logic [RAMP_W-1:0]    rem;
  logic [RAMP_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [GAIN_W-1:0]    quo_next;
  logic [RAMP_W-1:0]    rem_next;

  always_comb begin
    logic [RAMP_W:0] sh;
    quo_next = quo;
    rem_next = rem;
    for (int k = 0; k < DIV_STEP; k++) begin
      sh       = {rem_next, quo_next[GAIN_W-1]};
      quo_next = {quo_next[GAIN_W-2:0], 1'b0};
      if (sh >= {1'b0, dvs}) begin
        sh          = sh - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = sh[RAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_CYCLES);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/rgm_lane.sv =====
// one lane: gain multiply, round to nearest, saturate
module rgm_lane import rgm_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [GAIN_W-1:0]      gain,
  input  logic                          active,
  input  lane_ctrl_t                    ctrl,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PW = SAMPLE_BITS + GAIN_W + 1;
  localparam int QW = PW - FRAC_BITS;
  localparam logic signed [QW-1:0] MAXV =
    {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [QW-1:0] MINV = ~MAXV;

  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          rounded;
  logic signed [QW-1:0]          quot;
  logic signed [SAMPLE_BITS-1:0] sat;

  assign rounded = prod + PW'(1 << (FRAC_BITS - 1));
  assign quot    = rounded[PW-1:FRAC_BITS];

  always_comb begin
    if (quot > MAXV) begin
      sat = MAXV[SAMPLE_BITS-1:0];
    end else if (quot < MINV) begin
      sat = MINV[SAMPLE_BITS-1:0];
    end else begin
      sat = quot[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PW'(sample) * PW'($signed({1'b0, gain}));
    end
    if (ctrl.sat_en) begin
      result <= active ? sat : '0;
    end
  end

endmodule

// ===== sv/ramped_gain_multichannel_unit.sv =====
// top level: per-frame ramped gain over parallel lanes
// flow: an accepted item passes the multiply, saturate and hold states to its result, and
//   a buffer-start frame first waits in the divide state for the increment divider
// items: the control takes one item at a time and the next only after hold hands on the
//   result; the divider resolves 4 quotient bits a cycle
// reset: synchronous, restores unity gain, zero step and register defaults
module ramped_gain_multichannel_unit import rgm_pkg::*; #(
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rgm_in_if.sink                samples,
  rgm_out_if.source             scaled
);

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_MUL, ST_SAT, ST_HOLD} state_t;

  localparam int LW = LANES * SAMPLE_BITS;

  state_t                   state;
  logic [GAIN_W-1:0]        target_gain;
  logic [RAMP_W-1:0]        ramp_frames;
  logic [CHAN_W-1:0]        active_channels;
  logic [GAIN_W-1:0]        current_gain;
  logic signed [STEP_W-1:0] gain_step;
  logic [LW-1:0]            sample_r;
  logic                     diff_nz;
  logic                     diff_neg;
  logic [LW-1:0]            out_lane_r;
  logic [GAIN_W-1:0]        gain_applied_r;
  logic                     out_valid;

  logic                     accept;
  logic                     load_out;
  logic [GAIN_W-1:0]        gain_in;
  logic [STEP_W-1:0]        diff;
  logic [GAIN_W-1:0]        diff_mag;
  logic [RAMP_W-1:0]        ramp_eff;
  logic                     div_done;
  logic [GAIN_W-1:0]        div_quo;
  logic [GAIN_W-1:0]        step_mag;
  logic signed [STEP_W:0]   gain_sum;
  logic [GAIN_W-1:0]        gain_next;
  lane_ctrl_t               lane_ctrl;
  logic [LW-1:0]            lane_cat;

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign load_out      = (state == ST_HOLD) && (!out_valid || scaled.ready);

  assign gain_in  = samples.snap_to_target ? target_gain : current_gain;
  assign diff     = {1'b0, target_gain} - {1'b0, gain_in};
  assign diff_mag = diff[STEP_W-1] ? GAIN_W'(-diff) : diff[GAIN_W-1:0];
  assign ramp_eff = (ramp_frames == '0) ? RAMP_W'(1) : ramp_frames;
  assign step_mag = (div_quo == '0 && diff_nz) ? GAIN_W'(1) : div_quo;

  rgm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && samples.buffer_start),
    .dividend (diff_mag),
    .divisor  (ramp_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  // advance toward target, clamped at the present target
  always_comb begin
    gain_sum  = $signed({2'b00, current_gain}) + {gain_step[STEP_W-1], gain_step};
    gain_next = gain_sum[GAIN_W-1:0];
    if (gain_step > 0 && gain_sum > $signed({2'b00, target_gain})) begin
      gain_next = target_gain;
    end
    if (gain_step < 0 && gain_sum < $signed({2'b00, target_gain})) begin
      gain_next = target_gain;
    end
  end

  assign lane_ctrl.mul_en = (state == ST_MUL);
  assign lane_ctrl.sat_en = (state == ST_SAT);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [SAMPLE_BITS-1:0] lane_res;

    rgm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk    (clk),
      .sample (sample_r[i*SAMPLE_BITS +: SAMPLE_BITS]),
      .gain   (current_gain),
      .active ((CHAN_W+4)'(i) < {4'd0, active_channels}),
      .ctrl   (lane_ctrl),
      .result (lane_res)
    );

    assign lane_cat[i*SAMPLE_BITS +: SAMPLE_BITS] = lane_res;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= samples.sample_lane;
      diff_nz  <= (diff != '0);
      diff_neg <= diff[STEP_W-1];
    end
    if (load_out) begin
      out_lane_r     <= lane_cat;
      gain_applied_r <= current_gain;
    end
    if (rst) begin
      state           <= ST_IDLE;
      target_gain     <= UNITY_GAIN;
      ramp_frames     <= RAMP_RESET;
      active_channels <= CHAN_RESET;
      current_gain    <= UNITY_GAIN;
      gain_step       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TARGET: target_gain     <= cfg_wdata[GAIN_W-1:0];
          REG_RAMP:   ramp_frames     <= cfg_wdata[RAMP_W-1:0];
          REG_CHAN:   active_channels <= cfg_wdata[CHAN_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (scaled.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            current_gain <= gain_in;
            state        <= samples.buffer_start ? ST_DIV : ST_MUL;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            gain_step <= diff_neg ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
            state     <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_SAT;
        ST_SAT: state <= ST_HOLD;
        ST_HOLD: begin
          if (load_out) begin
            if (gain_step != 0) begin
              current_gain <= gain_next;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign scaled.valid        = out_valid;
  assign scaled.out_lane     = out_lane_r;
  assign scaled.gain_applied = gain_applied_r;

`ifndef SYNTH
  a_gain_hold: assert property (@(posedge clk) disable iff (rst)
    (!accept && !load_out) |=> current_gain == $past(current_gain))
    else $error("gain changed outside accept or result load");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_up_clamp: assert property (@(posedge clk) disable iff (rst)
    (load_out && gain_step > 0 && current_gain <= target_gain)
      |=> current_gain <= $past(target_gain))
    else $error("rising gain passed the target");

  a_down_clamp: assert property (@(posedge clk) disable iff (rst)
    (load_out && gain_step < 0 && current_gain >= target_gain)
      |=> current_gain >= $past(target_gain))
    else $error("falling gain passed the target");
`endif

endmodule
